/* design/min_heap_priority_queue_top_assert.svh */
// assertion macros for the heap queue
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// implication checked every clock, quiet during reset
`define MHPQ_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define MHPQ_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

/* design/mhpq_pkg.sv */
`timescale 1ns / 1ps
package mhpq_pkg;
   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_EXTRACT = 2'd1;
   localparam logic [1:0] MODE_PEEK    = 2'd2;
   localparam logic [1:0] MODE_CHANGE  = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;
endpackage

/* design/min_heap_priority_queue_top.sv */
`timescale 1ns / 1ps
// channel  | handshake              | word fields
// request  | start high, busy low   | req_mode, req_vertex, req_weight
// result   | rsp_valid, one cycle   | rsp_out_vertex, rsp_out_weight, rsp_status, rsp_entry_count
//
// one request at a time; busy is high from the accept edge until the strobe cycle.
// insert: per level climbed read parent, compare, move; then put the entry in its slot.
// extract: read root, then last entry; per level sunk read both children, compare, move; put.
// peek: reads the root only; a full, empty or absent case goes to done after any scan.
// change-key: scan slots to the match, then an insert or extract style sift or in-place put.
// reset clears count, state, strobe; slots hold nothing until written; receiver cannot stall.
module min_heap_priority_queue_top #(
   parameter int CAPACITY    = 256,
   parameter int VERTEX_BITS = 16,
   parameter int WEIGHT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [VERTEX_BITS-1:0]        req_vertex,
   input  logic [WEIGHT_BITS-1:0]        req_weight,
   output logic                          rsp_valid,
   output logic [VERTEX_BITS-1:0]        rsp_out_vertex,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_entry_count
);
   import mhpq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = VERTEX_BITS + WEIGHT_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCAN_CHK, S_ROOT_CHK, S_LAST_RD, S_LAST_LD, S_UP_RD, S_UP_CMP,
      S_DN_RDL, S_DN_RDR, S_DN_CMP, S_MOVE, S_PUT, S_DONE
   } state_type;

   // slot memory: vertex in the upper bits, weight in the lower
   logic [EW-1:0] mem [CAPACITY];
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] pos_ff;         // hole where the moving entry sits
   logic [AW-1:0] oth_ff;         // parent or chosen child
   logic [CW-1:0] scan_ff;        // scan index, reaches the count
   logic [EW-1:0] cur_ff;         // moving entry, written once it settles
   logic [EW-1:0] oth_e_ff;       // entry at the other slot
   logic          rgt_ok_ff;
   logic          down_ff;        // sift direction
   logic [1:0]    mode_ff;
   logic [VERTEX_BITS-1:0] vtx_ff;
   logic [WEIGHT_BITS-1:0] wgt_ff;

   logic [VERTEX_BITS-1:0] ov_ff;
   logic [WEIGHT_BITS-1:0] ow_ff;
   logic [1:0]             st_ff;
   logic                   valid_ff;

   function automatic logic [WEIGHT_BITS-1:0] wof(logic [EW-1:0] e);
      return e[WEIGHT_BITS-1:0];
   endfunction
   function automatic logic [VERTEX_BITS-1:0] vof(logic [EW-1:0] e);
      return e[EW-1:WEIGHT_BITS];
   endfunction

   // parent of the hole
   logic [AW-1:0] par_w;
   assign par_w = (pos_ff - AW'(1)) >> 1;

   // child indices in wide arithmetic so range checks are exact
   logic [CW+1:0] left_w, right_w;
   assign left_w  = {{(CW-AW+1){1'b0}}, pos_ff, 1'b0} + (CW+2)'(1);
   assign right_w = left_w + (CW+2)'(1);
   logic left_in, right_in;
   assign left_in  = left_w  < {2'b00, count_ff};
   assign right_in = right_w < {2'b00, count_ff};

   // read address and write port, driven from state; idle reads the root
   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = cur_ff;
      case (state_ff)
         S_SCAN:    rd_addr = scan_ff[AW-1:0];
         S_LAST_RD: rd_addr = count_ff[AW-1:0];
         S_UP_RD:   rd_addr = par_w;
         S_DN_RDL:  rd_addr = left_w[AW-1:0];
         S_DN_RDR:  rd_addr = right_w[AW-1:0];
         S_MOVE: begin
            wr_en = 1'b1; wr_data = oth_e_ff;
         end
         S_PUT:     wr_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               valid_ff <= 1'b0;
               if (start) begin
                  mode_ff <= req_mode;
                  vtx_ff  <= req_vertex;
                  wgt_ff  <= req_weight;
                  case (req_mode)
                     MODE_INSERT: begin
                        ov_ff <= req_vertex;
                        ow_ff <= req_weight;
                        if (count_ff >= CW'(CAPACITY)) begin
                           st_ff <= ST_FULL; state_ff <= S_DONE;
                        end else begin
                           st_ff    <= ST_OK;
                           cur_ff   <= {req_vertex, req_weight};
                           pos_ff   <= count_ff[AW-1:0];
                           count_ff <= count_ff + CW'(1);
                           down_ff  <= 1'b0;
                           // new entry climbs from the last slot
                           state_ff <= (count_ff == '0) ? S_PUT : S_UP_RD;
                        end
                     end
                     MODE_EXTRACT, MODE_PEEK: begin
                        ov_ff <= '0;
                        ow_ff <= '0;
                        if (count_ff == '0) begin
                           st_ff <= ST_EMPTY; state_ff <= S_DONE;
                        end else begin
                           st_ff <= ST_OK; state_ff <= S_ROOT_CHK;
                        end
                     end
                     default: begin
                        ov_ff    <= req_vertex;
                        ow_ff    <= '0;
                        st_ff    <= ST_OK;
                        scan_ff  <= '0;
                        state_ff <= S_SCAN;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (scan_ff >= count_ff) begin
                  st_ff <= ST_ABSENT; state_ff <= S_DONE;
               end else begin
                  pos_ff   <= scan_ff[AW-1:0];
                  state_ff <= S_SCAN_CHK;
               end
            end
            S_SCAN_CHK: begin
               if (vof(rd_data_ff) == vtx_ff) begin
                  ow_ff  <= wgt_ff;
                  cur_ff <= {vtx_ff, wgt_ff};
                  if (wgt_ff < wof(rd_data_ff)) begin
                     down_ff  <= 1'b0;
                     state_ff <= (pos_ff == '0) ? S_PUT : S_UP_RD;
                  end else if (wgt_ff > wof(rd_data_ff)) begin
                     down_ff  <= 1'b1;
                     state_ff <= S_DN_RDL;
                  end else begin
                     // same key, rewrite in place
                     down_ff  <= 1'b0;
                     state_ff <= S_PUT;
                  end
               end else begin
                  scan_ff  <= scan_ff + CW'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_ROOT_CHK: begin
               ov_ff <= vof(rd_data_ff);
               ow_ff <= wof(rd_data_ff);
               if (mode_ff == MODE_PEEK) state_ff <= S_DONE;
               else begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_LAST_RD;
               end
            end
            S_LAST_RD: state_ff <= S_LAST_LD;
            S_LAST_LD: begin
               // last entry sinks from the root
               cur_ff   <= rd_data_ff;
               pos_ff   <= '0;
               down_ff  <= 1'b1;
               state_ff <= S_DN_RDL;
            end
            S_UP_RD: begin
               oth_ff   <= par_w;
               state_ff <= S_UP_CMP;
            end
            S_UP_CMP: begin
               if (wof(cur_ff) < wof(rd_data_ff)) begin
                  oth_e_ff <= rd_data_ff;
                  state_ff <= S_MOVE;
               end else state_ff <= S_PUT;
            end
            S_DN_RDL: begin
               if (!left_in) state_ff <= S_PUT;
               else state_ff <= S_DN_RDR;
            end
            S_DN_RDR: begin
               oth_e_ff  <= rd_data_ff;
               oth_ff    <= left_w[AW-1:0];
               rgt_ok_ff <= right_in;
               state_ff  <= S_DN_CMP;
            end
            S_DN_CMP: begin
               // rd_data holds the right child here
               if (rgt_ok_ff && wof(rd_data_ff) < wof(oth_e_ff)
                   && wof(rd_data_ff) < wof(cur_ff)) begin
                  oth_e_ff <= rd_data_ff;
                  oth_ff   <= right_w[AW-1:0];
                  state_ff <= S_MOVE;
               end else if (wof(oth_e_ff) < wof(cur_ff)) begin
                  state_ff <= S_MOVE;
               end else state_ff <= S_PUT;
            end
            S_MOVE: begin
               // other entry fills the hole, hole moves to its slot
               pos_ff <= oth_ff;
               if (down_ff) state_ff <= S_DN_RDL;
               else state_ff <= (oth_ff == '0) ? S_PUT : S_UP_RD;
            end
            S_PUT: state_ff <= S_DONE;
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_out_vertex  = ov_ff;
   assign rsp_out_weight  = ow_ff;
   assign rsp_status      = st_ff;
   assign rsp_entry_count = count_ff;

   logic full_ins;
   assign full_ins = state_ff == S_IDLE && start && req_mode == MODE_INSERT
                     && count_ff == CW'(CAPACITY);

`include "min_heap_priority_queue_top_assert.svh"
   `MHPQ_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count over capacity")
   `MHPQ_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_valid, !busy, "strobe while busy")
   `MHPQ_ASSERT_NXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "strobe too long")
   `MHPQ_ASSERT_NXT(a_done_strobe, clock, reset, state_ff == S_DONE, rsp_valid && !busy, "done without strobe")
   `MHPQ_ASSERT_NXT(a_full_keep, clock, reset, full_ins, count_ff == CW'(CAPACITY), "full insert changed count")
endmodule
